FILE: hw/rtl/ptst_pkg.sv
// Package for the process/thread slot table.
// Holds command codes, status codes and the control/status structs shared by
// the controller, the datapath and the top level. No dependencies.
`default_nettype none

package ptst_pkg;

    localparam logic [2:0] MODE_ADD_PROC  = 3'd0;
    localparam logic [2:0] MODE_ADD_THR   = 3'd1;
    localparam logic [2:0] MODE_FIND_TID  = 3'd2;
    localparam logic [2:0] MODE_FIND_PID  = 3'd3;
    localparam logic [2:0] MODE_REM_THR   = 3'd4;
    localparam logic [2:0] MODE_REM_PROC  = 3'd5;
    localparam logic [2:0] MODE_RD_PH     = 3'd6;
    localparam logic [2:0] MODE_RD_TH     = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_STALE = 2'd3;

    typedef struct packed {
        logic load;
        logic rd;
        logic finish;
    } ptst_cmd_t;

    typedef struct packed {
        logic scan;
        logic hit;
        logic last;
    } ptst_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/ptst_dp.sv
// Datapath of the process/thread slot table: item registers, slot memories,
// valid bits, scan counter, result evaluation and the result register.
// Depends on ptst_pkg.
`default_nettype none

module ptst_dp #(
    parameter int PROCESS_SLOTS       = 64,
    parameter int THREADS_PER_PROCESS = 8,
    parameter int HANDLE_WIDTH        = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ptst_pkg::ptst_cmd_t   cmd,
    output ptst_pkg::ptst_stat_t       st,
    input  wire logic [2:0]            mode,
    input  wire logic [5:0]            process_slot,
    input  wire logic [2:0]            thread_slot,
    input  wire logic [31:0]           process_handle_in,
    input  wire logic [31:0]           process_os_id,
    input  wire logic [31:0]           thread_handle_in,
    input  wire logic [31:0]           thread_os_id,
    output logic [1:0]                 status,
    output logic [5:0]                 found_process_slot,
    output logic [2:0]                 found_thread_slot,
    output logic [31:0]                handle_out,
    output logic                       any_process_left
);

    localparam int PS  = PROCESS_SLOTS;
    localparam int TPP = THREADS_PER_PROCESS;
    localparam int HW  = HANDLE_WIDTH;
    localparam int PW  = $clog2(PS);
    localparam int TW  = (TPP > 1) ? $clog2(TPP) : 1;
    localparam int CW  = $clog2(PS + 1);

    logic [2:0]  mode_reg;
    logic [5:0]  ps_reg;
    logic [2:0]  ts_reg;
    logic [31:0] ph_reg;
    logic [31:0] pid_reg;
    logic [31:0] th_reg;
    logic [31:0] tid_reg;

    logic [PW-1:0] cnt_reg;
    logic [PW-1:0] p_d_reg;
    logic          pv_d_reg;
    logic          rok_d_reg;
    logic [PS-1:0] pv_reg;
    logic [PS-1:0] rok_reg;
    logic [CW-1:0] vcount_reg;

    logic [TPP-1:0]          thr_v_mem [PS];
    logic [TPP-1:0][HW-1:0]  thr_h_mem [PS];
    logic [TPP-1:0][31:0]    thr_i_mem [PS];
    logic [HW-1:0]           ph_mem    [PS];
    logic [31:0]             pid_mem   [PS];

    logic [TPP-1:0]          vrow_rd_reg;
    logic [TPP-1:0][HW-1:0]  rh_rd_reg;
    logic [TPP-1:0][31:0]    ri_rd_reg;
    logic [HW-1:0]           ph_rd_reg;
    logic [31:0]             pid_rd_reg;

    logic          ps_ok;
    logic          ts_ok;
    logic [PW-1:0] ps_idx;
    logic [TW-1:0] ts_idx;
    logic          scan_mode;
    logic [PW-1:0] rd_addr;
    logic [TPP-1:0] vrow;
    logic [TPP-1:0] mvec;
    logic [TPP-1:0] free_oh;
    logic [TPP-1:0] ts_oh;
    logic           free_any;
    logic [TW-1:0]  free_idx;
    logic           match_any;
    logic [TW-1:0]  match_idx;
    logic           hit;
    logic           thr_we;
    logic           proc_we;
    logic           rem_we;
    logic           rem_dec;
    logic [TPP-1:0] wvrow;
    logic [TPP-1:0] lane_we;
    logic [1:0]     st_c;
    logic [5:0]     fps_c;
    logic [2:0]     fts_c;
    logic [31:0]    h_c;
    logic           left_c;

    assign ps_ok     = 32'(ps_reg) < 32'(PS);
    assign ts_ok     = 32'(ts_reg) < 32'(TPP);
    assign ps_idx    = PW'(ps_reg);
    assign ts_idx    = TW'(ts_reg);
    assign scan_mode = mode_reg inside {ptst_pkg::MODE_ADD_PROC, ptst_pkg::MODE_FIND_TID,
                                        ptst_pkg::MODE_FIND_PID};
    assign rd_addr   = scan_mode ? cnt_reg : ps_idx;
    assign vrow      = rok_d_reg ? vrow_rd_reg : '0;
    assign ts_oh     = TPP'(1) << ts_idx;
    assign free_oh   = TPP'(1) << free_idx;

    // hold the item
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ps_reg  <= process_slot;
            ts_reg  <= thread_slot;
            ph_reg  <= process_handle_in;
            pid_reg <= process_os_id;
            th_reg  <= thread_handle_in;
            tid_reg <= thread_os_id;
        end
        if (cmd.rd)
        begin
            p_d_reg   <= rd_addr;
            pv_d_reg  <= pv_reg[rd_addr];
            rok_d_reg <= rok_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ptst_pkg::MODE_ADD_PROC;
            cnt_reg  <= '0;
        end
        else if (cmd.load)
        begin
            mode_reg <= mode;
            cnt_reg  <= '0;
        end
        else if (cmd.rd && scan_mode)
        begin
            cnt_reg <= cnt_reg + PW'(1);
        end
    end

    // slot memories
    always_ff @(posedge clk)
    begin
        if (thr_we)
        begin
            thr_v_mem[p_d_reg] <= wvrow;
            for (int l = 0; l < TPP; l++)
            begin
                if (lane_we[l])
                begin
                    thr_h_mem[p_d_reg][l] <= HW'(th_reg);
                    thr_i_mem[p_d_reg][l] <= tid_reg;
                end
            end
        end
        if (proc_we)
        begin
            ph_mem[p_d_reg]  <= HW'(ph_reg);
            pid_mem[p_d_reg] <= pid_reg;
        end
        if (cmd.rd)
        begin
            vrow_rd_reg <= thr_v_mem[rd_addr];
            rh_rd_reg   <= thr_h_mem[rd_addr];
            ri_rd_reg   <= thr_i_mem[rd_addr];
            ph_rd_reg   <= ph_mem[rd_addr];
            pid_rd_reg  <= pid_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg     <= '0;
            rok_reg    <= '0;
            vcount_reg <= '0;
        end
        else
        begin
            if (proc_we)
            begin
                pv_reg[p_d_reg] <= 1'b1;
                vcount_reg      <= vcount_reg + CW'(1);
            end
            if (rem_we)
            begin
                pv_reg[p_d_reg] <= 1'b0;
                vcount_reg      <= vcount_reg - CW'(rem_dec);
            end
            if (thr_we)
            begin
                rok_reg[p_d_reg] <= 1'b1;
            end
        end
    end

    always_comb
    begin
        free_any  = 1'b0;
        free_idx  = '0;
        match_any = 1'b0;
        match_idx = '0;
        for (int l = 0; l < TPP; l++)
        begin
            mvec[l] = vrow[l] && (ri_rd_reg[l] == tid_reg);
        end
        for (int l = TPP - 1; l >= 0; l--)
        begin
            if (!vrow[l])
            begin
                free_any = 1'b1;
                free_idx = TW'(l);
            end
            if (mvec[l])
            begin
                match_any = 1'b1;
                match_idx = TW'(l);
            end
        end
    end

    assign rem_dec = ps_ok && pv_d_reg;

    always_comb
    begin
        st_c    = ptst_pkg::ST_MISS;
        fps_c   = '0;
        fts_c   = '0;
        h_c     = '0;
        left_c  = 1'b0;
        hit     = 1'b0;
        thr_we  = 1'b0;
        proc_we = 1'b0;
        rem_we  = 1'b0;
        wvrow   = vrow;
        lane_we = '0;
        unique case (mode_reg)
            ptst_pkg::MODE_ADD_PROC:
            begin
                hit = !pv_d_reg;
                if (!pv_d_reg)
                begin
                    st_c    = ptst_pkg::ST_OK;
                    fps_c   = 6'(p_d_reg);
                    proc_we = cmd.finish;
                    thr_we  = cmd.finish;
                    wvrow   = TPP'(1);
                    lane_we = TPP'(1);
                end
                else
                begin
                    st_c = ptst_pkg::ST_FULL;
                end
            end
            ptst_pkg::MODE_ADD_THR:
            begin
                if (ps_ok)
                begin
                    if (free_any)
                    begin
                        st_c    = ptst_pkg::ST_OK;
                        fps_c   = ps_reg;
                        fts_c   = 3'(free_idx);
                        thr_we  = cmd.finish;
                        wvrow   = vrow | free_oh;
                        lane_we = free_oh;
                    end
                    else
                    begin
                        st_c = ptst_pkg::ST_FULL;
                    end
                end
            end
            ptst_pkg::MODE_FIND_TID:
            begin
                hit = pv_d_reg && match_any;
                if (hit)
                begin
                    st_c  = ptst_pkg::ST_OK;
                    fps_c = 6'(p_d_reg);
                    fts_c = 3'(match_idx);
                end
            end
            ptst_pkg::MODE_FIND_PID:
            begin
                hit = pv_d_reg && (pid_rd_reg == pid_reg);
                if (hit)
                begin
                    st_c  = ptst_pkg::ST_OK;
                    fps_c = 6'(p_d_reg);
                end
            end
            ptst_pkg::MODE_REM_THR:
            begin
                if (ps_ok && ts_ok)
                begin
                    if (!vrow[ts_idx])
                        st_c = ptst_pkg::ST_STALE;
                    else if (!pv_d_reg)
                        st_c = ptst_pkg::ST_MISS;
                    else
                        st_c = ptst_pkg::ST_OK;
                    thr_we = cmd.finish;
                    wvrow  = vrow & ~ts_oh;
                end
            end
            ptst_pkg::MODE_REM_PROC:
            begin
                if (ps_ok)
                begin
                    st_c   = pv_d_reg ? ptst_pkg::ST_OK : ptst_pkg::ST_STALE;
                    rem_we = cmd.finish;
                end
                left_c = vcount_reg != CW'(rem_dec);
            end
            ptst_pkg::MODE_RD_PH:
            begin
                if (ps_ok && pv_d_reg)
                begin
                    st_c = ptst_pkg::ST_OK;
                    h_c  = 32'(ph_rd_reg);
                end
            end
            ptst_pkg::MODE_RD_TH:
            begin
                if (ps_ok && ts_ok && pv_d_reg && vrow[ts_idx])
                begin
                    st_c = ptst_pkg::ST_OK;
                    h_c  = 32'(rh_rd_reg[ts_idx]);
                end
            end
            default:
            begin
                st_c = ptst_pkg::ST_MISS;
            end
        endcase
    end

    assign st.scan = scan_mode;
    assign st.hit  = hit;
    assign st.last = p_d_reg == PW'(PS - 1);

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status             <= st_c;
            found_process_slot <= fps_c;
            found_thread_slot  <= fts_c;
            handle_out         <= h_c;
            any_process_left   <= left_c;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/ptst_ctrl.sv
// Controller of the process/thread slot table: sequences load, memory reads,
// the slot scan and the result handoff; owns the channel handshakes.
// Depends on ptst_pkg.
`default_nettype none

module ptst_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    input  wire ptst_pkg::ptst_stat_t  st,
    output ptst_pkg::ptst_cmd_t        cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       can_finish;

    assign can_finish = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RD;
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EV;
            end
            S_EV:
            begin
                if (can_finish)
                begin
                    if (!st.scan || st.hit || st.last)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.rd = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.finish)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while held");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("finished beat not presented");

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_RD && !out_valid_next) || state_reg == S_RD)
        else $error("accepted beat not followed by a read");

    a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!cmd.rd && !cmd.finish))
        else $error("load overlaps work on previous beat");

endmodule

`default_nettype wire

FILE: hw/rtl/process_thread_slot_table.sv
// Top level of the process/thread slot table.
// Instantiates ptst_ctrl and ptst_dp; uses ptst_pkg.
//
//   channel | signals                               | direction
//   in      | in_valid/in_ready, mode .. thread_os_id | command beat in
//   out     | out_valid/out_ready, status .. any_process_left | result beat out
//
// Direct commands (add thread, removes, handle reads) go through the read and
// evaluate states into the result register. Add process and both lookups walk
// the process slots one per cycle through the row memory read port, pausing while
// a result is still held; a scan ends at a hit or after the last slot.
// Reset clears the valid bits at once; no clearing pass is needed.
// A held result does not block the next accept; a new result waits while the
// previous one is still held.
`default_nettype none

module process_thread_slot_table #(
    parameter int PROCESS_SLOTS       = 64,
    parameter int THREADS_PER_PROCESS = 8,
    parameter int HANDLE_WIDTH        = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [2:0]  mode,
    input  wire logic [5:0]  process_slot,
    input  wire logic [2:0]  thread_slot,
    input  wire logic [31:0] process_handle_in,
    input  wire logic [31:0] process_os_id,
    input  wire logic [31:0] thread_handle_in,
    input  wire logic [31:0] thread_os_id,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [1:0]       status,
    output logic [5:0]       found_process_slot,
    output logic [2:0]       found_thread_slot,
    output logic [31:0]      handle_out,
    output logic             any_process_left
);

    ptst_pkg::ptst_cmd_t  cmd;
    ptst_pkg::ptst_stat_t st;

    ptst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .st        (st),
        .cmd       (cmd)
    );

    ptst_dp #(
        .PROCESS_SLOTS       (PROCESS_SLOTS),
        .THREADS_PER_PROCESS (THREADS_PER_PROCESS),
        .HANDLE_WIDTH        (HANDLE_WIDTH)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .st                 (st),
        .mode               (mode),
        .process_slot       (process_slot),
        .thread_slot        (thread_slot),
        .process_handle_in  (process_handle_in),
        .process_os_id      (process_os_id),
        .thread_handle_in   (thread_handle_in),
        .thread_os_id       (thread_os_id),
        .status             (status),
        .found_process_slot (found_process_slot),
        .found_thread_slot  (found_thread_slot),
        .handle_out         (handle_out),
        .any_process_left   (any_process_left)
    );

endmodule

`default_nettype wire

FILE: tb/sv/process_thread_slot_table_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for process_thread_slot_table: directed and random commands
// over a valid/ready stream, each result checked against an in-bench table model.
// Depends on ptst_pkg and the process_thread_slot_table RTL.

module process_thread_slot_table_tb;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int DRAIN_CYCLES = 100;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_AT = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int PAUSE_AT = 900;

    typedef struct packed {
        logic [2:0]  mode;
        logic [5:0]  pslot;
        logic [2:0]  tslot;
        logic [31:0] phandle;
        logic [31:0] pid;
        logic [31:0] thandle;
        logic [31:0] tid;
        logic        drain_first;
    } tbl_cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  pslot;
        logic [2:0]  tslot;
        logic [31:0] handle;
        logic        any_left;
    } tbl_rsp_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  mode = '0;
    logic [5:0]  process_slot = '0;
    logic [2:0]  thread_slot = '0;
    logic [31:0] process_handle_in = '0;
    logic [31:0] process_os_id = '0;
    logic [31:0] thread_handle_in = '0;
    logic [31:0] thread_os_id = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [5:0]  found_process_slot;
    logic [2:0]  found_thread_slot;
    logic [31:0] handle_out;
    logic        any_process_left;

    process_thread_slot_table uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .mode               (mode),
        .process_slot       (process_slot),
        .thread_slot        (thread_slot),
        .process_handle_in  (process_handle_in),
        .process_os_id      (process_os_id),
        .thread_handle_in   (thread_handle_in),
        .thread_os_id       (thread_os_id),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .status             (status),
        .found_process_slot (found_process_slot),
        .found_thread_slot  (found_thread_slot),
        .handle_out         (handle_out),
        .any_process_left   (any_process_left)
    );

    tbl_cmd_t cmd_q[$];
    tbl_rsp_t rsp_q[$];
    int total_items = 0;
    int accepted_cnt = 0;
    int err_cnt = 0;
    int cycle_cnt = 0;

    // table model state
    bit   [63:0] pv = '0;
    logic [31:0] ph_mem [64];
    logic [31:0] pid_mem [64];
    bit   [7:0]  tv [64];
    logic [31:0] th_mem [64][8];
    logic [31:0] tid_mem [64][8];

    // valid bits as seen by the stimulus generator
    bit   [63:0] gen_pv = '0;
    bit   [7:0]  gen_tv [64];
    logic [31:0] id_pool [16];

    function automatic tbl_rsp_t tbl_apply(tbl_cmd_t c);
        tbl_rsp_t r;
        int p;
        int t;
        bit done;
        r = '0;
        r.status = ptst_pkg::ST_MISS;
        done = 1'b0;
        case (c.mode)
            ptst_pkg::MODE_ADD_PROC:
            begin
                r.status = ptst_pkg::ST_FULL;
                for (p = 0; p < 64 && !done; p++)
                begin
                    if (!pv[p])
                    begin
                        ph_mem[p] = c.phandle;
                        pid_mem[p] = c.pid;
                        tv[p] = 8'b1;
                        th_mem[p][0] = c.thandle;
                        tid_mem[p][0] = c.tid;
                        pv[p] = 1'b1;
                        r.status = ptst_pkg::ST_OK;
                        r.pslot = 6'(p);
                        done = 1'b1;
                    end
                end
            end
            ptst_pkg::MODE_ADD_THR:
            begin
                r.status = ptst_pkg::ST_FULL;
                for (t = 0; t < 8 && !done; t++)
                begin
                    if (!tv[c.pslot][t])
                    begin
                        th_mem[c.pslot][t] = c.thandle;
                        tid_mem[c.pslot][t] = c.tid;
                        tv[c.pslot][t] = 1'b1;
                        r.status = ptst_pkg::ST_OK;
                        r.pslot = c.pslot;
                        r.tslot = 3'(t);
                        done = 1'b1;
                    end
                end
            end
            ptst_pkg::MODE_FIND_TID:
            begin
                for (p = 0; p < 64 && !done; p++)
                    for (t = 0; t < 8 && !done; t++)
                        if (pv[p] && tv[p][t] && tid_mem[p][t] == c.tid)
                        begin
                            r.status = ptst_pkg::ST_OK;
                            r.pslot = 6'(p);
                            r.tslot = 3'(t);
                            done = 1'b1;
                        end
            end
            ptst_pkg::MODE_FIND_PID:
            begin
                for (p = 0; p < 64 && !done; p++)
                    if (pv[p] && pid_mem[p] == c.pid)
                    begin
                        r.status = ptst_pkg::ST_OK;
                        r.pslot = 6'(p);
                        done = 1'b1;
                    end
            end
            ptst_pkg::MODE_REM_THR:
            begin
                if (!tv[c.pslot][c.tslot])
                    r.status = ptst_pkg::ST_STALE;
                else if (!pv[c.pslot])
                    r.status = ptst_pkg::ST_MISS;
                else
                    r.status = ptst_pkg::ST_OK;
                tv[c.pslot][c.tslot] = 1'b0;
            end
            ptst_pkg::MODE_REM_PROC:
            begin
                r.status = pv[c.pslot] ? ptst_pkg::ST_OK : ptst_pkg::ST_STALE;
                pv[c.pslot] = 1'b0;
                r.any_left = |pv;
            end
            ptst_pkg::MODE_RD_PH:
            begin
                if (pv[c.pslot])
                begin
                    r.status = ptst_pkg::ST_OK;
                    r.handle = ph_mem[c.pslot];
                end
            end
            default:
            begin
                if (pv[c.pslot] && tv[c.pslot][c.tslot])
                begin
                    r.status = ptst_pkg::ST_OK;
                    r.handle = th_mem[c.pslot][c.tslot];
                end
            end
        endcase
        return r;
    endfunction

    function automatic void gen_track(tbl_cmd_t c);
        int i;
        bit done;
        done = 1'b0;
        case (c.mode)
            ptst_pkg::MODE_ADD_PROC:
                for (i = 0; i < 64 && !done; i++)
                    if (!gen_pv[i])
                    begin
                        gen_pv[i] = 1'b1;
                        gen_tv[i] = 8'b1;
                        done = 1'b1;
                    end
            ptst_pkg::MODE_ADD_THR:
                for (i = 0; i < 8 && !done; i++)
                    if (!gen_tv[c.pslot][i])
                    begin
                        gen_tv[c.pslot][i] = 1'b1;
                        done = 1'b1;
                    end
            ptst_pkg::MODE_REM_THR: gen_tv[c.pslot][c.tslot] = 1'b0;
            ptst_pkg::MODE_REM_PROC: gen_pv[c.pslot] = 1'b0;
            default: ;
        endcase
    endfunction

    function automatic void queue_cmd(tbl_cmd_t c);
        gen_track(c);
        cmd_q.push_back(c);
    endfunction

    function automatic tbl_cmd_t mk_cmd(logic [2:0] m, logic [5:0] ps, logic [2:0] ts,
                                        logic [31:0] ph, logic [31:0] pid,
                                        logic [31:0] th, logic [31:0] tid);
        tbl_cmd_t c;
        c.mode = m;
        c.pslot = ps;
        c.tslot = ts;
        c.phandle = ph;
        c.pid = pid;
        c.thandle = th;
        c.tid = tid;
        c.drain_first = 1'b0;
        return c;
    endfunction

    function automatic logic [2:0] pick_mode(bit fill);
        int fill_w [8] = '{45, 18, 10, 8, 6, 2, 6, 5};
        int drain_w [8] = '{5, 10, 12, 10, 15, 30, 9, 9};
        int r;
        int i;
        r = $urandom_range(0, 99);
        for (i = 0; i < 8; i++)
        begin
            r -= fill ? fill_w[i] : drain_w[i];
            if (r < 0)
                return 3'(i);
        end
        return ptst_pkg::MODE_RD_TH;
    endfunction

    function automatic logic [5:0] pick_proc();
        int k;
        int i;
        k = $urandom_range(0, 63);
        if (gen_pv != 0 && $urandom_range(0, 3) != 0)
            for (i = 0; i < 64; i++)
                if (gen_pv[(k + i) % 64])
                    return 6'((k + i) % 64);
        return 6'(k);
    endfunction

    function automatic logic [2:0] pick_thread(logic [5:0] p);
        int k;
        int i;
        k = $urandom_range(0, 7);
        if (gen_tv[p] != 0 && $urandom_range(0, 9) < 7)
            for (i = 0; i < 8; i++)
                if (gen_tv[p][(k + i) % 8])
                    return 3'((k + i) % 8);
        return 3'(k);
    endfunction

    function automatic logic [31:0] pick_id();
        if ($urandom_range(0, 99) < 65)
            return id_pool[$urandom_range(0, 15)];
        return $urandom;
    endfunction

    function automatic tbl_cmd_t rand_cmd(bit fill);
        tbl_cmd_t c;
        c.mode = pick_mode(fill);
        c.pslot = pick_proc();
        if (c.mode == ptst_pkg::MODE_ADD_THR && $urandom_range(0, 1) == 0)
            c.pslot = 6'($urandom_range(0, 3));
        c.tslot = pick_thread(c.pslot);
        c.phandle = $urandom;
        c.pid = pick_id();
        c.thandle = $urandom;
        c.tid = pick_id();
        c.drain_first = 1'b0;
        return c;
    endfunction

    function automatic bit idle_on();
        return accepted_cnt < total_items - 200 && (accepted_cnt / 100) % 3 != 2;
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        tbl_cmd_t c;
        int i;
        bit fill;
        foreach (gen_tv[i])
            gen_tv[i] = '0;
        foreach (tv[i])
            tv[i] = '0;
        foreach (id_pool[i])
            id_pool[i] = $urandom;
        id_pool[0] = '0;
        id_pool[1] = '1;

        queue_cmd(mk_cmd(ptst_pkg::MODE_FIND_TID, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_FIND_PID, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_REM_THR, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_REM_PROC, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_RD_PH, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_RD_TH, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_ADD_PROC, '1, '1, '1, '1, '1, '1));
        queue_cmd(mk_cmd(ptst_pkg::MODE_ADD_PROC, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_ADD_THR, 0, 0, 0, 0, 32'hAAAA_AAAA, 32'h5555_5555));
        // thread added under a process slot that is not valid
        queue_cmd(mk_cmd(ptst_pkg::MODE_ADD_THR, 63, 0, 0, 0, 32'h0BAD_F00D, 32'h1234_5678));
        queue_cmd(mk_cmd(ptst_pkg::MODE_FIND_TID, 0, 0, 0, 0, 0, 32'h1234_5678));
        queue_cmd(mk_cmd(ptst_pkg::MODE_FIND_TID, 0, 0, 0, 0, 0, '1));
        queue_cmd(mk_cmd(ptst_pkg::MODE_FIND_TID, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_FIND_PID, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_RD_PH, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_RD_TH, 0, 1, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_REM_THR, 63, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_REM_THR, 0, 1, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_REM_THR, 0, 1, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_RD_TH, 0, 1, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_REM_PROC, 1, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_REM_PROC, 1, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_RD_PH, 1, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_REM_PROC, 0, 0, 0, 0, 0, 0));
        queue_cmd(mk_cmd(ptst_pkg::MODE_ADD_PROC, 0, 0, 32'h8000_0001, 32'h7FFF_FFFE,
                         32'h0000_FFFF, 32'hFFFF_0000));

        fill = 1'b1;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 120 == 119)
                fill = !fill;
            c = rand_cmd(fill);
            c.drain_first = (i == 0 || i == PAUSE_AT);
            queue_cmd(c);
        end
        total_items = cmd_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt != total_items)
            @(posedge clk);
        while (rsp_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("FAILURE");
            $finish;
        end
    end

    tbl_cmd_t cur_cmd;
    bit       holding;
    int       send_gap = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            holding = in_valid;
            if (in_valid && in_ready)
            begin
                rsp_q.push_back(tbl_apply(cur_cmd));
                accepted_cnt++;
                holding = 1'b0;
                if (idle_on() && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 9);
            end
            if (!holding)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (cmd_q.size() != 0 && !(cmd_q[0].drain_first && rsp_q.size() != 0))
                begin
                    cur_cmd = cmd_q.pop_front();
                    mode <= cur_cmd.mode;
                    process_slot <= cur_cmd.pslot;
                    thread_slot <= cur_cmd.tslot;
                    process_handle_in <= cur_cmd.phandle;
                    process_os_id <= cur_cmd.pid;
                    thread_handle_in <= cur_cmd.thandle;
                    thread_os_id <= cur_cmd.tid;
                    holding = 1'b1;
                end
            end
            in_valid <= holding;
        end
    end

    int hold_left = 0;
    bit hold_done = 1'b0;

    // one long receiver hold-off so the block backs up into its input
    always @(posedge clk)
    begin
        if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    tbl_rsp_t exp_rsp;
    tbl_rsp_t got_rsp;
    bit       rdy;
    int       rdy_gap = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_rsp.status = status;
                got_rsp.pslot = found_process_slot;
                got_rsp.tslot = found_thread_slot;
                got_rsp.handle = handle_out;
                got_rsp.any_left = any_process_left;
                if (rsp_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("unexpected result beat: status=%0d slot=%0d/%0d",
                                 status, found_process_slot, found_thread_slot);
                end
                else
                begin
                    exp_rsp = rsp_q.pop_front();
                    if (got_rsp !== exp_rsp)
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                        begin
                            $write("mismatch: exp st=%0d ps=%0d ts=%0d h=%h left=%0d",
                                   exp_rsp.status, exp_rsp.pslot, exp_rsp.tslot,
                                   exp_rsp.handle, exp_rsp.any_left);
                            $display(" | got st=%0d ps=%0d ts=%0d h=%h left=%0d",
                                     got_rsp.status, got_rsp.pslot, got_rsp.tslot,
                                     got_rsp.handle, got_rsp.any_left);
                        end
                    end
                end
            end
            if (hold_left > 0)
            begin
                rdy = 1'b0;
            end
            else if (rdy_gap > 0)
            begin
                rdy_gap--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
                if (idle_on() && $urandom_range(0, 7) == 0)
                    rdy_gap = $urandom_range(1, 9);
            end
            out_ready <= rdy;
        end
    end

endmodule

FILE: filelist.f
hw/rtl/ptst_pkg.sv
hw/rtl/ptst_dp.sv
hw/rtl/ptst_ctrl.sv
hw/rtl/process_thread_slot_table.sv
tb/sv/process_thread_slot_table_tb.sv
